[sv/cra_pkg.sv]
package cra_pkg;

    // field widths of the request and result items
    localparam int CMD_W  = 2;
    localparam int SIZE_W = 17;
    localparam int ST_W   = 2;
    localparam int OFF_W  = 16;

    // stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_W = ((SIZE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OFF_W + SIZE_W + 7) / 8) * 8;

    localparam longint unsigned MAX_CAPACITY_DEF = 64'd65536;
    localparam longint unsigned CAP_RESET_VALUE  = 64'd65536;

    // request codes
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [ST_W-1:0] ST_BADSIZE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic execute;  // apply the latched request, load the result register
    } t_dp_cmd;

endpackage

[sv/cra_ctrl.sv]
module cra_ctrl
    import cra_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_res_valid,
    input  logic    i_res_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_res_valid;
    logic   n_res_valid;
    logic   w_slot_free;

    assign w_slot_free = !r_res_valid || i_res_ready;

    always_comb begin
        n_state       = r_state;
        n_res_valid   = r_res_valid && !i_res_ready;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait until the result register can take a new result
                if (w_slot_free) begin
                    o_cmd.execute = 1'b1;
                    n_res_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;

endmodule

[sv/cra_datapath.sv]
module cra_datapath
    import cra_pkg::*;
#(
    parameter longint unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [CMD_W-1:0]  i_req_cmd,
    input  logic [SIZE_W-1:0] i_req_size,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    output logic [ST_W-1:0]   o_status,
    output logic [OFF_W-1:0]  o_offset,
    output logic [SIZE_W-1:0] o_free_bytes
);

    // state width follows the largest ring, math width also covers a request size
    localparam int CW = $clog2(MAX_CAPACITY + 64'd1);
    localparam int DW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam logic [CW-1:0] CAP_MAX = CW'(MAX_CAPACITY);
    localparam logic [CW-1:0] CAP_RST =
        (CAP_RESET_VALUE > MAX_CAPACITY) ? CW'(MAX_CAPACITY) : CW'(CAP_RESET_VALUE);

    logic [CMD_W-1:0]  r_cmd;
    logic [SIZE_W-1:0] r_size;

    logic [CW-1:0] r_cap;
    logic [CW-1:0] r_head;
    logic [CW-1:0] r_tail;
    logic [CW-1:0] r_free;
    logic [CW-1:0] r_wrap;
    logic [CW-1:0] n_head;
    logic [CW-1:0] n_tail;
    logic [CW-1:0] n_free;
    logic [CW-1:0] n_wrap;
    logic [CW-1:0] w_cfg_cap;

    logic [ST_W-1:0]   r_status;
    logic [OFF_W-1:0]  r_offset;
    logic [SIZE_W-1:0] r_free_bytes;
    logic [ST_W-1:0]   n_status;
    logic [DW-1:0]     n_off;

    logic [DW-1:0] c_cap;
    logic [DW-1:0] c_head;
    logic [DW-1:0] c_tail;
    logic [DW-1:0] c_free;
    logic [DW-1:0] c_wrap;
    logic [DW-1:0] c_size;
    logic [DW-1:0] c_rel_free;
    logic [DW-1:0] c_rel_head;
    logic [DW-1:0] c_nfree;
    logic          w_fwd;

    assign c_cap  = DW'(r_cap);
    assign c_head = DW'(r_head);
    assign c_tail = DW'(r_tail);
    assign c_free = DW'(r_free);
    assign c_wrap = DW'(r_wrap);
    assign c_size = DW'(r_size);

    assign c_rel_free = c_free + c_size;
    assign c_rel_head = c_head + c_size;

    // a forward allocation applies when not wrapped, or when the ring is wholly free
    assign w_fwd = (c_head < c_tail) || ((c_head == c_tail) && (c_free == c_cap));

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_free   = r_free;
        n_wrap   = r_wrap;
        n_status = ST_DONE;
        n_off    = '0;
        case (r_cmd)
            CMD_ALLOC: begin
                if ((c_size == '0) || (c_size > c_cap)) begin
                    n_status = ST_BADSIZE;
                end else if (c_size > c_free) begin
                    n_status = ST_REFUSED;
                end else if (w_fwd) begin
                    if (c_size <= c_cap - c_tail) begin
                        n_off  = c_tail;
                        n_tail = CW'(c_tail + c_size);
                        n_free = CW'(c_free - c_size);
                    end else if (c_size <= c_head) begin
                        // skip the short tail and restart at zero
                        n_wrap = r_tail;
                        n_tail = CW'(c_size);
                        n_free = CW'(c_free - c_size);
                    end else begin
                        n_status = ST_REFUSED;
                    end
                end else if (c_head == c_tail) begin
                    // full after wrap
                    n_status = ST_REFUSED;
                end else if (c_size <= c_head - c_tail) begin
                    n_off  = c_tail;
                    n_tail = CW'(c_tail + c_size);
                    n_free = CW'(c_free - c_size);
                end else begin
                    n_status = ST_REFUSED;
                end
            end
            CMD_RELEASE: begin
                if ((c_size == '0) || (c_size > c_cap - c_head) ||
                    (c_size > c_cap - c_free)) begin
                    n_status = ST_BADSIZE;
                end else if (c_rel_free == c_cap) begin
                    n_head = '0;
                    n_tail = '0;
                    n_free = r_cap;
                    n_wrap = r_cap;
                end else if (c_rel_head == c_wrap) begin
                    n_head = '0;
                    n_free = CW'(c_rel_free);
                    n_wrap = r_cap;
                end else begin
                    n_head = CW'(c_rel_head);
                    n_free = CW'(c_rel_free);
                end
            end
            CMD_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_free = r_cap;
                n_wrap = r_cap;
            end
            default: begin
            end
        endcase
    end

    assign c_nfree = DW'(n_free);

    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_cap = CW'(1);
        end else if (64'(i_cfg_wdata) > MAX_CAPACITY) begin
            w_cfg_cap = CAP_MAX;
        end else begin
            w_cfg_cap = CW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RST;
            r_head <= '0;
            r_tail <= '0;
            r_free <= CAP_RST;
            r_wrap <= CAP_RST;
        end else if (i_cfg_we) begin
            r_cap  <= w_cfg_cap;
            r_head <= '0;
            r_tail <= '0;
            r_free <= w_cfg_cap;
            r_wrap <= w_cfg_cap;
        end else if (i_cmd.execute) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_free <= n_free;
            r_wrap <= n_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd  <= i_req_cmd;
            r_size <= i_req_size;
        end
        if (i_cmd.execute) begin
            r_status     <= n_status;
            r_offset     <= n_off[OFF_W-1:0];
            r_free_bytes <= c_nfree[SIZE_W-1:0];
        end
    end

    assign o_status     = r_status;
    assign o_offset     = r_offset;
    assign o_free_bytes = r_free_bytes;

endmodule

[sv/contiguous_ring_allocator_top.sv]
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    tuser: cmd; tdata: req_size
// m_*       out  m_tvalid/m_tready    tuser: status; tdata: offset, free_bytes
// cfg       in   i_cfg_we             i_cfg_wdata: capacity
//
// a request is accepted in S_IDLE, then applied to the ring state in S_EXEC, which
// also loads the result register; no new request is accepted until S_EXEC is done
// the next request is accepted while a result still waits in the output register
// a stalled output holds the apply step until the result register frees up
// synchronous active-low reset gives an empty ring of 65536 bytes (clamped to the max)
module contiguous_ring_allocator_top
    import cra_pkg::*;
#(
    parameter longint unsigned MAX_CAPACITY = MAX_CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // req_size
    input  logic [CMD_W-1:0]     s_tuser,   // cmd
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // offset, free_bytes
    output logic [ST_W-1:0]      m_tuser,   // status
    // capacity register write
    input  logic                 i_cfg_we,
    input  logic [SIZE_W-1:0]    i_cfg_wdata
);

    t_dp_cmd           w_cmd;
    logic [ST_W-1:0]   w_status;
    logic [OFF_W-1:0]  w_offset;
    logic [SIZE_W-1:0] w_free_bytes;

    // sequencing of accept, apply and result transfer
    cra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .o_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .o_cmd       (w_cmd)
    );

    // ring pointers, free count, wrap mark and result register
    cra_datapath #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_req_cmd    (s_tuser),
        .i_req_size   (s_tdata[SIZE_W-1:0]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_status     (w_status),
        .o_offset     (w_offset),
        .o_free_bytes (w_free_bytes)
    );

    // pack the result: offset in the low bits, free count above, zero fill on top
    assign m_tdata = {{(M_TDATA_W - OFF_W - SIZE_W){1'b0}}, w_free_bytes, w_offset};
    assign m_tuser = w_status;

endmodule
